>>> hdl/scfr_pkg.sv
package scfr_pkg;

  localparam int NUM_DEVICES   = 8;
  localparam int TABLE_SLOTS   = 8;
  localparam int CHECKED_BYTES = 4;
  localparam int FRAME_LEN     = CHECKED_BYTES + 1;
  localparam int POS_W         = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int OUT_FIELDS_W  = 45;
  localparam int OUT_DATA_W    = 48;

  localparam logic [TABLE_SLOTS-1:0] ENTRY_MASK = TABLE_SLOTS'((1 << NUM_DEVICES) - 1);

  localparam logic [POS_W-1:0] POS_CHECKSUM = POS_W'(CHECKED_BYTES);
  localparam logic [POS_W-1:0] POS_DONE     = POS_W'(FRAME_LEN);

  typedef enum logic [1:0] {
    ROUTE_BAD       = 2'd0,
    ROUTE_INTERCEPT = 2'd1,
    ROUTE_POLL      = 2'd2,
    ROUTE_ADDRESSED = 2'd3
  } route_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERCEPT_EN = 3'd0,
    REG_DISK_ID      = 3'd1,
    REG_POLL_ID      = 3'd2,
    REG_FAIL_THRESH  = 3'd3,
    REG_ID_TABLE     = 3'd4,
    REG_DEV_PRESENT  = 3'd5,
    REG_POLL_LISTEN  = 3'd6,
    REG_UNUSED       = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                       intercept_enable;
    logic [7:0]                 disk_id;
    logic [7:0]                 poll_id;
    logic [TABLE_SLOTS*8-1:0]   id_table;
    logic [TABLE_SLOTS-1:0]     device_present;
    logic [TABLE_SLOTS-1:0]     poll_listeners;
  } route_cfg_t;

  typedef struct packed {
    route_t                 route;
    logic [TABLE_SLOTS-1:0] target_mask;
  } route_res_t;

endpackage

>>> hdl/scfr_route.sv
module scfr_route (
  input  scfr_pkg::route_cfg_t cfg,
  input  logic [7:0]           device,
  input  logic                 frame_ok,
  output scfr_pkg::route_res_t res
);

  logic [scfr_pkg::TABLE_SLOTS-1:0] match;

  // compare every table slot with the device byte in parallel
  always_comb begin
    for (int k = 0; k < scfr_pkg::TABLE_SLOTS; k++) begin
      match[k] = (cfg.id_table[8*k +: 8] == device);
    end
  end

  always_comb begin
    res.route       = scfr_pkg::ROUTE_BAD;
    res.target_mask = '0;
    if (frame_ok) begin
      if (cfg.intercept_enable && (device == cfg.disk_id)) begin
        res.route = scfr_pkg::ROUTE_INTERCEPT;
      end else if (device == cfg.poll_id) begin
        res.route       = scfr_pkg::ROUTE_POLL;
        res.target_mask = cfg.poll_listeners & cfg.device_present & scfr_pkg::ENTRY_MASK;
      end else begin
        res.route       = scfr_pkg::ROUTE_ADDRESSED;
        res.target_mask = match & cfg.device_present & scfr_pkg::ENTRY_MASK;
      end
    end
  end

endmodule

>>> hdl/sio_command_frame_receiver_top.sv
// Serial command frame receiver. Takes one byte per request on the in_ stream
// (device, command, aux low, aux high, checksum); in_tuser set restarts the frame
// at that byte. The first four bytes are summed with end-around carry and the
// sum is compared with the fifth byte, which yields one registered result
// request carrying the frame fields, its route (bad, disk intercept, poll
// broadcast, addressed) with the target table entries, and the speed mode. Bytes
// past the fifth give nothing until the next start. Every byte is processed in
// the cycle it is accepted, so the block takes one byte per clock while
// in_tready is high. Results go through a two-deep buffer (the output register
// plus one skid register), so in_tready comes straight from a register and
// drops only while both hold results that out_tready has not taken yet. After
// reset the speed mode is standard and the failure count is zero; a failed
// checksum counts up and, on reaching fail_threshold, clears the count and
// toggles the speed mode. Write configuration only while idle.
module sio_command_frame_receiver_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_wr_en,
  input  logic [scfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scfr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // byte stream in
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] rx_byte
  input  logic                              in_tuser,   // [0] frame_start
  // result stream out
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] frame_ok, [8:1] dev_byte, [16:9] command, [32:17] aux_value,
  // [34:33] route, [42:35] target_mask, [43] high_speed, [44] speed_changed,
  // [47:45] zero
  output logic [scfr_pkg::OUT_DATA_W-1:0]   out_tdata
);

  // configuration registers
  logic                                   intercept_en_r;
  logic [7:0]                             disk_id_r;
  logic [7:0]                             poll_id_r;
  logic [7:0]                             fail_thresh_r;
  logic [scfr_pkg::TABLE_SLOTS*8-1:0]     id_table_r;
  logic [scfr_pkg::TABLE_SLOTS-1:0]       dev_present_r;
  logic [scfr_pkg::TABLE_SLOTS-1:0]       poll_listen_r;

  // frame state
  logic [scfr_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]                 sum_r, sum_nxt;
  logic [7:0]                 dev_r, cmd_r, aux_lo_r, aux_hi_r;
  logic [7:0]                 fail_cnt_r, fail_cnt_nxt;
  logic                       speed_r, speed_nxt;

  // result output register and the skid register behind it
  logic                                   out_valid_r, out_valid_nxt;
  logic [scfr_pkg::OUT_FIELDS_W-1:0]      out_data_r, out_data_nxt;
  logic                                   skid_valid_r, skid_valid_nxt;
  logic [scfr_pkg::OUT_FIELDS_W-1:0]      skid_data_r, skid_data_nxt;

  logic                         in_acc;
  logic                         out_pop;
  logic                         res_push;
  logic [scfr_pkg::OUT_FIELDS_W-1:0] res_data;
  logic [scfr_pkg::POS_W-1:0]   pos_eff;
  logic [7:0]                   sum_eff;
  logic [8:0]                   sum_wide;
  logic                         frame_ok;
  logic                         is_check;
  logic                         changed;
  logic [7:0]                   fail_inc;
  scfr_pkg::route_cfg_t         route_cfg;
  scfr_pkg::route_res_t         route_res;

  assign in_tready  = !skid_valid_r;
  assign in_acc     = in_tvalid && in_tready;
  assign out_pop    = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(scfr_pkg::OUT_DATA_W - scfr_pkg::OUT_FIELDS_W){1'b0}}, out_data_r};

  // configuration writes; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intercept_en_r <= 1'b0;
      disk_id_r      <= 8'd49;
      poll_id_r      <= 8'd79;
      fail_thresh_r  <= 8'd10;
      id_table_r     <= '0;
      dev_present_r  <= '0;
      poll_listen_r  <= '0;
    end else if (cfg_wr_en) begin
      case (scfr_pkg::cfg_reg_t'(cfg_index))
        scfr_pkg::REG_INTERCEPT_EN: intercept_en_r <= cfg_wdata[0];
        scfr_pkg::REG_DISK_ID:      disk_id_r      <= cfg_wdata[7:0];
        scfr_pkg::REG_POLL_ID:      poll_id_r      <= cfg_wdata[7:0];
        scfr_pkg::REG_FAIL_THRESH:  fail_thresh_r  <= cfg_wdata[7:0];
        scfr_pkg::REG_ID_TABLE:     id_table_r     <= cfg_wdata[scfr_pkg::TABLE_SLOTS*8-1:0];
        scfr_pkg::REG_DEV_PRESENT:  dev_present_r  <= cfg_wdata[scfr_pkg::TABLE_SLOTS-1:0];
        scfr_pkg::REG_POLL_LISTEN:  poll_listen_r  <= cfg_wdata[scfr_pkg::TABLE_SLOTS-1:0];
        default: ;
      endcase
    end
  end

  assign route_cfg.intercept_enable = intercept_en_r;
  assign route_cfg.disk_id          = disk_id_r;
  assign route_cfg.poll_id          = poll_id_r;
  assign route_cfg.id_table         = id_table_r;
  assign route_cfg.device_present   = dev_present_r;
  assign route_cfg.poll_listeners   = poll_listen_r;

  // a start byte restarts position and sum before the byte is used
  assign pos_eff  = in_tuser ? '0 : pos_r;
  assign sum_eff  = in_tuser ? 8'd0 : sum_r;
  assign sum_wide = {1'b0, sum_eff} + {1'b0, in_tdata};
  assign is_check = (pos_eff == scfr_pkg::POS_CHECKSUM);
  assign frame_ok = (sum_eff == in_tdata);
  assign fail_inc = fail_cnt_r + 8'd1;

  scfr_route u_route (
    .cfg      (route_cfg),
    .device   (dev_r),
    .frame_ok (frame_ok),
    .res      (route_res)
  );

  always_comb begin
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    fail_cnt_nxt = fail_cnt_r;
    speed_nxt    = speed_r;
    changed      = 1'b0;
    res_push     = 1'b0;
    res_data     = '0;
    if (in_acc) begin
      pos_nxt = pos_eff;
      sum_nxt = sum_eff;
      if (pos_eff < scfr_pkg::POS_CHECKSUM) begin
        // fold the carry back into the sum
        sum_nxt = sum_wide[7:0] + {7'd0, sum_wide[8]};
        pos_nxt = pos_eff + 1'b1;
      end else if (is_check) begin
        pos_nxt = scfr_pkg::POS_DONE;
        if (!frame_ok) begin
          fail_cnt_nxt = fail_inc;
          if (fail_inc == fail_thresh_r) begin
            fail_cnt_nxt = 8'd0;
            speed_nxt    = !speed_r;
            changed      = 1'b1;
          end
        end
        res_push = 1'b1;
        res_data = {changed, speed_nxt, route_res.target_mask, route_res.route,
                    aux_hi_r, aux_lo_r, cmd_r, dev_r, frame_ok};
      end
    end
  end

  // advance the skid entry into the output register when the output drains;
  // park a new result in the skid register only while the output is held
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_pop) begin
      out_valid_nxt  = skid_valid_r;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end
    if (res_push) begin
      if (out_valid_nxt) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res_data;
      end else begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res_data;
      end
    end
  end

  // hold the frame bytes by position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r    <= 8'd0;
      cmd_r    <= 8'd0;
      aux_lo_r <= 8'd0;
      aux_hi_r <= 8'd0;
    end else if (in_acc) begin
      case (pos_eff)
        3'd0:    dev_r    <= in_tdata;
        3'd1:    cmd_r    <= in_tdata;
        3'd2:    aux_lo_r <= in_tdata;
        3'd3:    aux_hi_r <= in_tdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      sum_r        <= 8'd0;
      fail_cnt_r   <= 8'd0;
      speed_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      sum_r        <= sum_nxt;
      fail_cnt_r   <= fail_cnt_nxt;
      speed_r      <= speed_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  // position never runs past the done marker
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= scfr_pkg::POS_DONE)
    else $error("byte position out of range");

  // a bad frame targets no entry
  a_bad_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r[34:33] == scfr_pkg::ROUTE_BAD)) |-> (out_data_r[42:35] == '0))
    else $error("bad frame carries a target mask");

  // only a failed checksum toggles the speed
  a_toggle_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[44]) |-> !out_data_r[0])
    else $error("speed toggled on a good frame");

  // no fresh result follows an accepted byte other than a checksum
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !(is_check)) |=> !(out_valid_r && !$past(out_valid_r)))
    else $error("result without a checksum byte");

  // the speed mode changes only together with a result
  a_speed_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    (speed_r != speed_nxt) |-> (in_acc && is_check))
    else $error("speed mode changed outside a frame end");

  // the skid register only ever sits behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full with the output empty");

endmodule

>>> dv/sio_command_frame_receiver_top_tb.sv
`timescale 1ns / 100ps

module sio_command_frame_receiver_top_tb;

  typedef logic [scfr_pkg::CFG_DATA_W-1:0]  cfg_word_t;
  typedef logic [scfr_pkg::TABLE_SLOTS-1:0] slot_mask_t;

  // One result request as it sits on out_tdata (first member is the top bit).
  typedef struct packed {
    logic [2:0]                       pad;
    logic                             speed_changed;
    logic                             high_speed;
    logic [scfr_pkg::TABLE_SLOTS-1:0] target_mask;
    scfr_pkg::route_t                 route;
    logic [15:0]                      aux_value;
    logic [7:0]                       command;
    logic [7:0]                       dev_byte;
    logic                             frame_ok;
  } frame_result_t;

  // Tracks the frame assembly, the routing tables and the failure counter,
  // and holds the results that the accepted bytes must still produce.
  class command_frame_scoreboard;
    logic                               intercept_on;
    logic [7:0]                         disk_dev;
    logic [7:0]                         poll_dev;
    logic [7:0]                         fail_limit;
    logic [scfr_pkg::TABLE_SLOTS*8-1:0] table_ids;
    logic [scfr_pkg::TABLE_SLOTS-1:0]   table_present;
    logic [scfr_pkg::TABLE_SLOTS-1:0]   table_listen;

    logic [scfr_pkg::POS_W-1:0] pos;
    logic [7:0]                 sum;
    logic [7:0]                 dev;
    logic [7:0]                 cmd;
    logic [7:0]                 aux_lo;
    logic [7:0]                 aux_hi;
    logic [7:0]                 fail_count;
    logic                       speed;

    frame_result_t pending_frames[$];
    int            errors;

    function new();
      intercept_on  = 1'b0;
      disk_dev      = 8'd49;
      poll_dev      = 8'd79;
      fail_limit    = 8'd10;
      table_ids     = '0;
      table_present = '0;
      table_listen  = '0;
      pos           = '0;
      sum           = '0;
      dev           = '0;
      cmd           = '0;
      aux_lo        = '0;
      aux_hi        = '0;
      fail_count    = '0;
      speed         = 1'b0;
      errors        = 0;
    endfunction

    function void apply_write(scfr_pkg::cfg_reg_t idx, cfg_word_t v);
      case (idx)
        scfr_pkg::REG_INTERCEPT_EN: intercept_on  = v[0];
        scfr_pkg::REG_DISK_ID:      disk_dev      = v[7:0];
        scfr_pkg::REG_POLL_ID:      poll_dev      = v[7:0];
        scfr_pkg::REG_FAIL_THRESH:  fail_limit    = v[7:0];
        scfr_pkg::REG_ID_TABLE:     table_ids     = v[scfr_pkg::TABLE_SLOTS*8-1:0];
        scfr_pkg::REG_DEV_PRESENT:  table_present = v[scfr_pkg::TABLE_SLOTS-1:0];
        scfr_pkg::REG_POLL_LISTEN:  table_listen  = v[scfr_pkg::TABLE_SLOTS-1:0];
        default: ;
      endcase
    endfunction

    // Returns 1 when the byte took part in a frame, 0 when it was dropped.
    function bit take_byte(logic [7:0] b, logic start);
      frame_result_t                    r;
      logic [8:0]                       t;
      logic [scfr_pkg::TABLE_SLOTS-1:0] hits;
      if (start) begin
        pos = '0;
        sum = '0;
      end
      if (pos >= scfr_pkg::FRAME_LEN) return 1'b0;
      if (pos < scfr_pkg::CHECKED_BYTES) begin
        case (pos)
          0: dev = b;
          1: cmd = b;
          2: aux_lo = b;
          default: aux_hi = b;
        endcase
        // end-around carry: fold bit 8 back into the low byte
        t   = {1'b0, sum} + {1'b0, b};
        sum = t[7:0] + {7'd0, t[8]};
        pos = pos + 1'b1;
        return 1'b1;
      end
      pos             = scfr_pkg::POS_DONE;
      r               = '0;
      r.frame_ok      = (sum == b);
      r.dev_byte      = dev;
      r.command       = cmd;
      r.aux_value     = {aux_hi, aux_lo};
      if (r.frame_ok) begin
        if (intercept_on && dev == disk_dev) begin
          r.route = scfr_pkg::ROUTE_INTERCEPT;
        end else if (dev == poll_dev) begin
          r.route       = scfr_pkg::ROUTE_POLL;
          r.target_mask = table_listen & table_present & scfr_pkg::ENTRY_MASK;
        end else begin
          hits = '0;
          for (int k = 0; k < scfr_pkg::TABLE_SLOTS; k++)
            hits[k] = (table_ids[8*k +: 8] == dev);
          r.route       = scfr_pkg::ROUTE_ADDRESSED;
          r.target_mask = hits & table_present & scfr_pkg::ENTRY_MASK;
        end
      end else begin
        r.route    = scfr_pkg::ROUTE_BAD;
        fail_count = fail_count + 8'd1;
        if (fail_count == fail_limit) begin
          fail_count      = '0;
          speed           = ~speed;
          r.speed_changed = 1'b1;
        end
      end
      r.high_speed = speed;
      pending_frames.push_back(r);
      return 1'b1;
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_frame(logic [scfr_pkg::OUT_DATA_W-1:0] data);
      frame_result_t got;
      frame_result_t want;
      got = data;
      if (pending_frames.size() == 0) begin
        $error("result request with nothing expected: %h", data);
        errors++;
        return;
      end
      want = pending_frames.pop_front();
      compare_field("frame_ok", want.frame_ok, got.frame_ok);
      compare_field("dev_byte", want.dev_byte, got.dev_byte);
      compare_field("command", want.command, got.command);
      compare_field("aux_value", want.aux_value, got.aux_value);
      compare_field("route", want.route, got.route);
      compare_field("target_mask", want.target_mask, got.target_mask);
      compare_field("high_speed", want.high_speed, got.high_speed);
      compare_field("speed_changed", want.speed_changed, got.speed_changed);
      compare_field("pad", want.pad, got.pad);
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_wr_en = 1'b0;
  logic [scfr_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  cfg_word_t                         cfg_wdata = '0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [7:0]                        in_tdata = '0;    // [7:0] rx_byte
  logic                              in_tuser = 1'b0;  // [0] frame_start
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  // [0] frame_ok, [8:1] dev_byte, [16:9] command, [32:17] aux_value,
  // [34:33] route, [42:35] target_mask, [43] high_speed, [44] speed_changed,
  // [47:45] zero
  logic [scfr_pkg::OUT_DATA_W-1:0]   out_tdata;

  command_frame_scoreboard sb = new();
  int                      consumed_bytes = 0;  // bytes that were not dropped
  bit                      idle_on = 1'b1;      // random gaps and stalls allowed

  sio_command_frame_receiver_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin : clock_gen
    forever #10 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin : watchdog
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Sample both handshakes at the same edge the block does. Everything read
  // here is the pre-edge value, since all drivers use nonblocking updates.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      if (sb.take_byte(in_tdata, in_tuser)) consumed_bytes++;
    end
    if (rst_n && out_tvalid && out_tready) sb.check_frame(out_tdata);
  end

  // Result side: alternate ready stretches with stall bursts while idling
  // is allowed; otherwise hold ready high.
  initial begin : result_sink
    repeat (12) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Offer one byte and hold it until the request is taken. An optional gap
  // comes first so that idle cycles land on every byte position.
  task automatic send_byte(input logic [7:0] b, input logic start);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
  endtask

  // Full frame with a start mark, then any extra bytes; a bad frame gets a corrupted checksum.
  task automatic send_frame(input logic [7:0] dev, input logic [7:0] cmd,
                            input logic [15:0] aux, input bit good, input int extras);
    logic [7:0] body[4];
    logic [8:0] t;
    logic [7:0] chk;
    body = '{dev, cmd, aux[7:0], aux[15:8]};
    chk  = '0;
    foreach (body[i]) begin
      t   = {1'b0, chk} + {1'b0, body[i]};
      chk = t[7:0] + {7'd0, t[8]};
    end
    if (!good) chk = chk ^ 8'($urandom_range(1, 255));
    foreach (body[i]) send_byte(body[i], i == 0);
    send_byte(chk, 1'b0);
    repeat (extras) send_byte(8'($urandom), 1'b0);
  endtask

  // Drop valid and hold until every expected result is out, then let the
  // result buffer settle before anything else happens. The first edge lets
  // the monitor note the byte that was just taken.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_frames.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Narrow registers get random junk above their width; it must be ignored.
  task automatic write_reg(input scfr_pkg::cfg_reg_t idx, input cfg_word_t v,
                           input int width);
    cfg_word_t junk;
    junk = {$urandom, $urandom};
    if (width < scfr_pkg::CFG_DATA_W && $urandom_range(0, 1) == 1) v = v | (junk << width);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.apply_write(idx, v);
  endtask

  // Draw a table byte from a small pool so that duplicate IDs show up.
  function automatic logic [7:0] pool_id(logic [7:0] disk);
    case ($urandom_range(0, 3))
      0: return disk;
      1: return 8'h12;
      2: return 8'h34;
      default: return 8'($urandom);
    endcase
  endfunction

  // Bias device bytes toward the IDs that steer routing.
  function automatic logic [7:0] pick_device();
    case ($urandom_range(0, 4))
      0: return sb.disk_dev;
      1: return sb.poll_dev;
      2, 3: return sb.table_ids[8*$urandom_range(0, scfr_pkg::TABLE_SLOTS-1) +: 8];
      default: return 8'($urandom);
    endcase
  endfunction

  // Program every register for one phase. The fail threshold normally sits a
  // little above the current count so the speed toggle keeps happening.
  task automatic program_phase(input int ph);
    logic                               ie;
    logic [7:0]                         disk;
    logic [7:0]                         poll;
    logic [7:0]                         thr;
    logic [scfr_pkg::TABLE_SLOTS*8-1:0] ids;
    slot_mask_t                         present;
    slot_mask_t                         listen;
    ie      = 1'b1;
    disk    = 8'($urandom);
    poll    = 8'($urandom);
    present = slot_mask_t'($urandom);
    listen  = slot_mask_t'($urandom);
    thr     = (sb.fail_count >= 8'd252) ? 8'hff
                                        : sb.fail_count + 8'($urandom_range(1, 3));
    for (int k = 0; k < scfr_pkg::TABLE_SLOTS; k++) ids[8*k +: 8] = pool_id(disk);
    case (ph)
      0: begin
        // disk and poll share an ID: the intercept must win
        disk    = 8'h31;
        poll    = 8'h31;
        present = '1;
        listen  = 8'ha5;
        for (int k = 0; k < scfr_pkg::TABLE_SLOTS; k++) ids[8*k +: 8] = pool_id(disk);
      end
      1: begin
        ie      = 1'b0;
        disk    = 8'h00;
        poll    = 8'hff;
        ids     = '0;
        present = '0;
        listen  = '1;
      end
      2: begin
        ie      = 1'b0;
        disk    = 8'hff;
        poll    = 8'h00;
        ids     = '1;
        present = '1;
        listen  = '1;
      end
      4: begin
        ie  = 1'b0;
        thr = 8'hff;
      end
      default: ;
    endcase
    write_reg(scfr_pkg::REG_INTERCEPT_EN, cfg_word_t'(ie), 1);
    write_reg(scfr_pkg::REG_DISK_ID, cfg_word_t'(disk), 8);
    write_reg(scfr_pkg::REG_POLL_ID, cfg_word_t'(poll), 8);
    write_reg(scfr_pkg::REG_FAIL_THRESH, cfg_word_t'(thr), 8);
    write_reg(scfr_pkg::REG_ID_TABLE, cfg_word_t'(ids), scfr_pkg::CFG_DATA_W);
    write_reg(scfr_pkg::REG_DEV_PRESENT, cfg_word_t'(present), 8);
    write_reg(scfr_pkg::REG_POLL_LISTEN, cfg_word_t'(listen), 8);
    write_reg(scfr_pkg::REG_UNUSED, {$urandom, $urandom}, scfr_pkg::CFG_DATA_W);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    int goal;
    int n;
    int pick;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset configuration.
    // First bytes after reset carry no start mark and still form a frame.
    repeat (5) send_byte(8'h00, 1'b0);
    // Past the fifth byte: dropped.
    send_byte(8'ha5, 1'b0);
    // All-ones fields; the checksum wraps through the end-around carry.
    send_frame(8'hff, 8'hff, 16'hffff, 1'b1, 0);
    // Partial frame to the poll ID, then a restart that completes.
    send_byte(8'h4f, 1'b1);
    send_byte(8'h12, 1'b0);
    send_frame(8'h4f, 8'h01, 16'h8000, 1'b1, 0);
    // Bad checksum on the disk ID with the intercept still off.
    send_frame(8'h31, 8'h53, 16'h1234, 1'b0, 0);

    // Random part in phases, each under its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      program_phase(ph);
      idle_on = (ph != 5);
      goal    = consumed_bytes + 237;
      while (consumed_bytes < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // well-formed frame, mostly good, now and then with trailing bytes
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
          send_frame(pick_device(), 8'($urandom), 16'($urandom),
                     $urandom_range(0, 3) != 0, n);
        end else if (pick < 85) begin
          // started frame cut short; the next frame restarts it
          n = $urandom_range(1, 4);
          send_byte(pick_device(), 1'b1);
          repeat (n - 1) send_byte(8'($urandom), 1'b0);
        end else begin
          // noise: random bytes, some of them start marks
          n = $urandom_range(1, 6);
          repeat (n) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 49) == 0) drain_results();
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_frames.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
